// File: rtl/sbqeq_pkg.sv
// Shared types, control codes and saturating fixed-point helpers for the
// stereo biquad equalizer. No dependencies.
package sbqeq_pkg;

  localparam int DEF_BANDS = 8;
  localparam int NTAPS     = 5;
  localparam int CIDX_W    = 6;
  localparam int SMP_W     = 16;
  localparam int ACC_W     = 32;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_SUB,
    ALU_SUB2,
    ALU_LDT,
    ALU_LDU,
    ALU_MIXT,
    ALU_FIN
  } alu_op_e;

  typedef enum logic [1:0] {
    FIN_ACC,
    FIN_LEFT,
    FIN_RIGHT
  } fin_e;

  typedef enum logic [1:0] {
    MUL_RD,
    MUL_D2,
    MUL_D1,
    MUL_ACC
  } mul_sel_e;

  typedef struct packed {
    logic     start;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     cap_d2;
    logic     cap_d1;
    alu_op_e  alu_op;
    fin_e     fin;
  } dp_ctrl_t;

  localparam acc_t ACC_MAX = 32'sh7FFF_FFFF;
  localparam acc_t ACC_MIN = 32'sh8000_0000;

  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic acc_t sat_sub(input acc_t a, input acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic acc_t sat_shl(input acc_t x, input int n);
    logic [2*ACC_W-1:0] w;
    w = {{ACC_W{x[ACC_W-1]}}, x} << n;
    if (w[2*ACC_W-1:ACC_W-1] != {(ACC_W+1){x[ACC_W-1]}}) begin
      return x[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return w[ACC_W-1:0];
  endfunction

  // doubled fractional product; only -1 * -1 overflows
  function automatic acc_t fmul(input smp_t a, input smp_t b);
    acc_t p;
    p = acc_t'(a) * acc_t'(b);
    if (p == 32'sh4000_0000) begin
      return ACC_MAX;
    end
    return p <<< 1;
  endfunction

  function automatic smp_t hi16(input acc_t x);
    return x[ACC_W-1:ACC_W-SMP_W];
  endfunction

endpackage

// File: rtl/sbqeq_if.sv
// Valid/ready stream interfaces for the equalizer input and result channels.
// Depends on sbqeq_pkg.
interface sbqeq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  sbqeq_pkg::smp_t                     sample_left;
  sbqeq_pkg::smp_t                     sample_right;
  logic [sbqeq_pkg::CIDX_W-1:0]        coeff_index;
  sbqeq_pkg::smp_t                     coeff_value;

  modport source (output valid, action, sample_left, sample_right, coeff_index, coeff_value,
                  input ready);
  modport sink   (input valid, action, sample_left, sample_right, coeff_index, coeff_value,
                  output ready);
endinterface

interface sbqeq_out_if;
  logic            valid;
  logic            ready;
  sbqeq_pkg::smp_t out_left;
  sbqeq_pkg::smp_t out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

// File: rtl/sbqeq_coef_ram.sv
// Coefficient store: one write port, one registered read port.
// Depends on sbqeq_pkg.
module sbqeq_coef_ram #(
  parameter int DEPTH = sbqeq_pkg::NTAPS * sbqeq_pkg::DEF_BANDS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  sbqeq_pkg::smp_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output sbqeq_pkg::smp_t rdata_o
);

  sbqeq_pkg::smp_t mem [DEPTH];
  sbqeq_pkg::smp_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

// File: rtl/sbqeq_dly_ram.sv
// Delay-line store for both channels, registered read, per-entry valid bits
// so that unwritten entries read as zero after reset. Depends on sbqeq_pkg.
module sbqeq_dly_ram #(
  parameter int AW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  sbqeq_pkg::smp_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output sbqeq_pkg::smp_t rdata_o
);

  localparam int DEPTH = 2 ** AW;

  sbqeq_pkg::smp_t  mem [DEPTH];
  sbqeq_pkg::smp_t  rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rv_q ? rd_q : '0;

endmodule

// File: rtl/sbqeq_dpath.sv
// Shared multiplier and saturating accumulator datapath, driven one step per
// cycle by the sequencer's control word. Depends on sbqeq_pkg.
module sbqeq_dpath (
  input  logic                clk_i,
  input  sbqeq_pkg::dp_ctrl_t ctrl_i,
  input  sbqeq_pkg::smp_t     coef_i,
  input  sbqeq_pkg::smp_t     dly_i,
  input  sbqeq_pkg::smp_t     left_i,
  input  sbqeq_pkg::smp_t     right_i,
  output sbqeq_pkg::smp_t     d1_o,
  output sbqeq_pkg::smp_t     d0_o,
  output sbqeq_pkg::smp_t     left_o,
  output sbqeq_pkg::smp_t     right_o
);

  sbqeq_pkg::acc_t acc_q, t_q, u_q, p_q;
  sbqeq_pkg::smp_t d1_q, d2_q, right_q, left_res_q;
  sbqeq_pkg::smp_t opnd;
  sbqeq_pkg::acc_t sum;
  sbqeq_pkg::smp_t fin_v;

  always_comb begin
    case (ctrl_i.mul_sel)
      sbqeq_pkg::MUL_RD:  opnd = dly_i;
      sbqeq_pkg::MUL_D2:  opnd = d2_q;
      sbqeq_pkg::MUL_D1:  opnd = d1_q;
      sbqeq_pkg::MUL_ACC: opnd = sbqeq_pkg::hi16(acc_q);
      default:            opnd = dly_i;
    endcase
  end

  assign sum   = sbqeq_pkg::sat_add(t_q, u_q);
  assign fin_v = sbqeq_pkg::hi16(sbqeq_pkg::sat_shl(sum, 6));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_q <= sbqeq_pkg::fmul(coef_i, opnd);
    end
    if (ctrl_i.cap_d2) begin
      d2_q <= dly_i;
    end
    if (ctrl_i.cap_d1) begin
      d1_q <= dly_i;
    end
    if (ctrl_i.start) begin
      acc_q   <= {{5{left_i[15]}}, left_i, 11'b0};
      right_q <= right_i;
    end else begin
      case (ctrl_i.alu_op)
        sbqeq_pkg::ALU_SUB:  acc_q <= sbqeq_pkg::sat_sub(acc_q, p_q);
        sbqeq_pkg::ALU_SUB2: acc_q <= sbqeq_pkg::sat_sub(acc_q, sbqeq_pkg::sat_shl(p_q, 1));
        sbqeq_pkg::ALU_LDT:  t_q <= p_q;
        sbqeq_pkg::ALU_LDU:  u_q <= p_q;
        sbqeq_pkg::ALU_MIXT: t_q <= sbqeq_pkg::sat_shl(sbqeq_pkg::sat_add(t_q, p_q), 3);
        sbqeq_pkg::ALU_FIN: begin
          case (ctrl_i.fin)
            sbqeq_pkg::FIN_ACC: acc_q <= sum;
            sbqeq_pkg::FIN_LEFT: begin
              left_res_q <= fin_v;
              acc_q      <= {{5{right_q[15]}}, right_q, 11'b0};
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign d1_o    = d1_q;
  assign d0_o    = sbqeq_pkg::hi16(acc_q);
  assign left_o  = left_res_q;
  assign right_o = fin_v;

endmodule

// File: rtl/stereo_biquad_cascade_equalizer.sv
// Stereo equalizer: BANDS direct-form-II biquads per channel, one shared
// coefficient table, separate delay lines. For each sample pair the single
// multiplier and accumulator visit each band of each channel in a slot of
// five coefficient reads through the one memory port plus a step to fold in
// the last product; the tail state then folds in the last product and, once
// the output register is free, finishes the result to close the last band.
// The next item may be taken while a result waits at the output register.
// Depends on sbqeq_pkg, sbqeq_if, sbqeq_coef_ram, sbqeq_dly_ram, sbqeq_dpath.
module stereo_biquad_cascade_equalizer #(
  parameter int BANDS = sbqeq_pkg::DEF_BANDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbqeq_in_if.sink    in_i,
  sbqeq_out_if.source out_o
);

  localparam int NCOEF = sbqeq_pkg::NTAPS * BANDS;
  localparam int CAW   = $clog2(NCOEF);
  localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int DAW   = BW + 2;
  localparam int XW    = (CAW > sbqeq_pkg::CIDX_W) ? CAW : sbqeq_pkg::CIDX_W;
  localparam logic [2:0] PH_LAST = 3'd5;
  localparam logic [BW-1:0] BAND_LAST = BW'(BANDS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_TAIL} state_e;

  state_e          st_q;
  logic [2:0]      ph_q;
  logic [BW-1:0]   band_q;
  logic            chan_q;
  logic [CAW-1:0]  cbase_q;
  logic            out_vld_q;
  sbqeq_pkg::smp_t out_left_q, out_right_q;

  logic            in_xfer, start, cwe, out_free, prev_ok, res_load;
  logic [XW-1:0]   cidx_x;
  logic [CAW-1:0]  craddr;
  logic [DAW-1:0]  draddr, dwaddr;
  logic            dwe;
  sbqeq_pkg::smp_t dwdata, coef_rd, dly_rd, d1, d0, left_res, right_res;
  sbqeq_pkg::dp_ctrl_t ctrl;

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign start      = in_xfer && !in_i.action;
  assign cidx_x     = XW'(in_i.coeff_index);
  assign cwe        = in_xfer && in_i.action && (int'(in_i.coeff_index) < NCOEF);
  assign out_free   = !out_vld_q || out_o.ready;
  assign prev_ok    = (band_q != '0) || chan_q;
  assign res_load   = (st_q == ST_TAIL) && (ph_q != 3'd0) && out_free;

  assign craddr = cbase_q + CAW'(ph_q);
  assign draddr = {chan_q, band_q, ph_q[0]};
  assign dwe    = (st_q == ST_RUN) && (ph_q == 3'd3 || ph_q == 3'd4);
  assign dwaddr = {chan_q, band_q, ph_q == 3'd4};
  assign dwdata = (ph_q == 3'd4) ? d0 : d1;

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = sbqeq_pkg::MUL_RD;
    ctrl.alu_op  = sbqeq_pkg::ALU_NOP;
    ctrl.fin     = sbqeq_pkg::FIN_ACC;
    ctrl.start   = start;
    if (st_q == ST_RUN) begin
      case (ph_q)
        3'd0: begin
          if (prev_ok) ctrl.alu_op = sbqeq_pkg::ALU_MIXT;
        end
        3'd1: begin
          ctrl.mul_en = 1'b1;
          ctrl.cap_d2 = 1'b1;
          if (prev_ok) begin
            ctrl.alu_op = sbqeq_pkg::ALU_FIN;
            ctrl.fin    = (band_q == '0) ? sbqeq_pkg::FIN_LEFT : sbqeq_pkg::FIN_ACC;
          end
        end
        3'd2: begin
          ctrl.mul_en = 1'b1;
          ctrl.cap_d1 = 1'b1;
          ctrl.alu_op = sbqeq_pkg::ALU_SUB;
        end
        3'd3: begin
          ctrl.mul_en  = 1'b1;
          ctrl.mul_sel = sbqeq_pkg::MUL_D2;
          ctrl.alu_op  = sbqeq_pkg::ALU_SUB2;
        end
        3'd4: begin
          ctrl.mul_en  = 1'b1;
          ctrl.mul_sel = sbqeq_pkg::MUL_D1;
          ctrl.alu_op  = sbqeq_pkg::ALU_LDT;
        end
        3'd5: begin
          ctrl.mul_en  = 1'b1;
          ctrl.mul_sel = sbqeq_pkg::MUL_ACC;
          ctrl.alu_op  = sbqeq_pkg::ALU_LDU;
        end
        default: ;
      endcase
    end else if (st_q == ST_TAIL) begin
      if (ph_q == 3'd0) begin
        ctrl.alu_op = sbqeq_pkg::ALU_MIXT;
      end else begin
        ctrl.alu_op = sbqeq_pkg::ALU_FIN;
        ctrl.fin    = sbqeq_pkg::FIN_RIGHT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ph_q        <= '0;
      band_q      <= '0;
      chan_q      <= 1'b0;
      cbase_q     <= '0;
      out_vld_q   <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
    end else begin
      if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            st_q    <= ST_RUN;
            ph_q    <= '0;
            band_q  <= '0;
            chan_q  <= 1'b0;
            cbase_q <= '0;
          end
        end
        ST_RUN: begin
          if (ph_q == PH_LAST) begin
            ph_q <= '0;
            if (band_q == BAND_LAST) begin
              band_q  <= '0;
              cbase_q <= '0;
              if (chan_q) begin
                st_q <= ST_TAIL;
              end else begin
                chan_q <= 1'b1;
              end
            end else begin
              band_q  <= band_q + 1'b1;
              cbase_q <= cbase_q + CAW'(sbqeq_pkg::NTAPS);
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_TAIL: begin
          if (ph_q == 3'd0) begin
            ph_q <= 3'd1;
          end else if (out_free) begin
            st_q        <= ST_IDLE;
            ph_q        <= '0;
            out_left_q  <= left_res;
            out_right_q <= right_res;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

  sbqeq_coef_ram #(
    .DEPTH (NCOEF),
    .AW    (CAW)
  ) u_coef (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (cidx_x[CAW-1:0]),
    .wdata_i (in_i.coeff_value),
    .raddr_i (craddr),
    .rdata_o (coef_rd)
  );

  sbqeq_dly_ram #(
    .AW (DAW)
  ) u_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (dwdata),
    .raddr_i (draddr),
    .rdata_o (dly_rd)
  );

  sbqeq_dpath u_dpath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coef_i  (coef_rd),
    .dly_i   (dly_rd),
    .left_i  (in_i.sample_left),
    .right_i (in_i.sample_right),
    .d1_o    (d1),
    .d0_o    (d0),
    .left_o  (left_res),
    .right_o (right_res)
  );

  a_tail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TAIL) |-> (band_q == '0 && chan_q && ph_q <= 3'd1))
    else $error("tail entered at wrong band or channel");

  a_tail_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN && ph_q == PH_LAST && band_q == BAND_LAST && chan_q)
    |=> (st_q == ST_TAIL && ph_q == 3'd0))
    else $error("last band did not hand over to tail");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TAIL && ph_q == 3'd1 && out_free) |=> (out_vld_q && st_q == ST_IDLE))
    else $error("finished pair not loaded into output register");

  a_run_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (ph_q <= PH_LAST && !cwe && !in_i.ready))
    else $error("phase out of range or transfer taken while busy");

endmodule

// File: tb/stereo_biquad_cascade_equalizer_test.sv
// Self-checking test of the stereo biquad cascade equalizer: directed rows and
// random coefficient sets and sample streams, checked against a local predictor.
// Depends on sbqeq_pkg, sbqeq_if and stereo_biquad_cascade_equalizer.
module stereo_biquad_cascade_equalizer_test;
  import sbqeq_pkg::*;

  localparam int BANDS = DEF_BANDS;
  localparam int NCOEF = NTAPS * BANDS;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 150;
  localparam int RAND_BLOCKS = 10;
  localparam int BLOCK_MIXED = 80;
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_COEF = 1'b1;
  localparam int TAP_B0 = 4;

  typedef enum int {COEF_GENTLE, COEF_FULL, COEF_EXTREME} coef_mode_e;

  typedef struct packed {
    logic              action;
    smp_t              left;
    smp_t              right;
    logic [CIDX_W-1:0] idx;
    smp_t              value;
    logic              typed;
    smp_t              exp_l;
    smp_t              exp_r;
  } row_t;

  typedef struct packed {
    smp_t l;
    smp_t r;
  } pair_t;

  localparam row_t DIR_ROWS [23] = '{
    '{ACT_FILTER, 16'sh7FFF, 16'sh8000, 6'd63, 16'sh8000, 1'b1, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh8000, 16'sh7FFF, 6'd0, 16'sh7FFF, 1'b1, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh0000, 16'sh0000, 6'd21, 16'sh1234, 1'b1, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh5555, 16'shAAAA, 6'd42, 16'shFFFF, 1'b1, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh7FFF, 16'sh8000, 6'd4, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd9, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd14, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd19, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd24, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd29, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd34, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd39, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd0, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd36, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd18, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd27, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd40, 16'sh1234, 1'b0, 16'sh0, 16'sh0},
    '{ACT_COEF, 16'sh0, 16'sh0, 6'd63, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh7FFF, 16'sh8000, 6'd0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh8000, 16'sh7FFF, 6'd0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh0000, 16'sh0000, 6'd0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'shFFFF, 16'sh0001, 6'd0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
    '{ACT_FILTER, 16'sh5555, 16'shAAAA, 6'd0, 16'sh0, 1'b0, 16'sh0, 16'sh0}
  };

  logic clk_i;
  logic rst_ni;

  sbqeq_in_if  in_if ();
  sbqeq_out_if out_if ();

  stereo_biquad_cascade_equalizer #(
    .BANDS(BANDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  smp_t  coef_tab [NCOEF];
  smp_t  delay_line [2][2*BANDS];
  pair_t eq_pending [$];

  logic in_typed;
  smp_t in_exp_l;
  smp_t in_exp_r;
  bit   sender_calm;
  int   items_in;
  int   coef_writes;
  int   pairs_checked;
  int   mismatches;
  int   idle_cycles;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint clip(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint frac(input smp_t a, input smp_t b);
    return clip(longint'(a) * longint'(b) * 2);
  endfunction

  function automatic longint lshift(input longint x, input int n);
    return clip(x * (longint'(1) << n));
  endfunction

  function automatic smp_t upper(input longint x);
    return smp_t'(x >>> 16);
  endfunction

  // one channel through the whole cascade; updates that channel's delays
  function automatic smp_t run_bands(input int ch, input smp_t x);
    longint acc;
    longint t;
    longint u;
    smp_t   d2;
    smp_t   d1;
    smp_t   d0;
    int     k;
    acc = longint'(x) * 2048;
    for (k = 0; k < BANDS; k++) begin
      d2 = delay_line[ch][2*k];
      d1 = delay_line[ch][2*k+1];
      acc = clip(acc - frac(coef_tab[NTAPS*k], d2));
      acc = clip(acc - lshift(frac(coef_tab[NTAPS*k+1], d1), 1));
      d0 = upper(acc);
      t = frac(coef_tab[NTAPS*k+2], d2);
      u = frac(coef_tab[NTAPS*k+3], d1);
      t = clip(t + frac(coef_tab[NTAPS*k+4], d0));
      t = lshift(t, 3);
      acc = clip(t + u);
      delay_line[ch][2*k] = d1;
      delay_line[ch][2*k+1] = d0;
    end
    return upper(lshift(acc, 6));
  endfunction

  function automatic smp_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (r < 5) begin
      return smp_t'(int'($urandom_range(0, 8191)) - 4096);
    end
    return smp_t'($urandom);
  endfunction

  function automatic smp_t rand_coef(input coef_mode_e mode, input int tap);
    int v;
    case (mode)
      COEF_GENTLE: begin
        if (tap == TAP_B0) begin
          v = $urandom_range(2048, 6144);
          if ($urandom_range(0, 3) == 0) begin
            v = -v;
          end
        end else begin
          v = int'($urandom_range(0, 8000)) - 4000;
        end
        return smp_t'(v);
      end
      COEF_FULL: return smp_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input row_t r);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= r.action;
    in_if.sample_left  <= r.left;
    in_if.sample_right <= r.right;
    in_if.coeff_index  <= r.idx;
    in_if.coeff_value  <= r.value;
    in_typed           <= r.typed;
    in_exp_l           <= r.exp_l;
    in_exp_r           <= r.exp_r;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  function automatic row_t coef_row(input int idx, input smp_t value);
    row_t r;
    r = '0;
    r.action = ACT_COEF;
    r.left   = smp_t'($urandom);
    r.right  = smp_t'($urandom);
    r.idx    = idx[CIDX_W-1:0];
    r.value  = value;
    return r;
  endfunction

  always @(posedge clk_i) begin : track
    bit    moved;
    pair_t want;
    smp_t  pl;
    smp_t  pr;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        pairs_checked++;
        if (eq_pending.size() == 0) begin
          $error("unexpected result: out_left %0d out_right %0d",
                 out_if.out_left, out_if.out_right);
          mismatches++;
        end else begin
          want = eq_pending.pop_front();
          if (out_if.out_left !== want.l) begin
            $error("out_left: expected %0d, got %0d", want.l, out_if.out_left);
            mismatches++;
          end
          if (out_if.out_right !== want.r) begin
            $error("out_right: expected %0d, got %0d", want.r, out_if.out_right);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        items_in++;
        if (in_if.action == ACT_COEF) begin
          coef_writes++;
          if (in_if.coeff_index < NCOEF) begin
            coef_tab[in_if.coeff_index] = in_if.coeff_value;
          end
        end else begin
          pl = run_bands(0, in_if.sample_left);
          pr = run_bands(1, in_if.sample_right);
          if (in_typed) begin
            pl = in_exp_l;
            pr = in_exp_r;
          end
          eq_pending.push_back('{l: pl, r: pr});
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stereo_biquad_cascade_equalizer verification failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int  stall_left;
    int  tick;
    bit  calm;
    bit  held;
    stall_left = 0;
    tick = 0;
    calm = 1'b0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 256 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      if (!held && pairs_checked >= 300) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  initial begin : stimulus
    row_t r;
    coef_mode_e mode;
    int i;
    int blk;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_FILTER;
    in_if.sample_left  <= '0;
    in_if.sample_right <= '0;
    in_if.coeff_index  <= '0;
    in_if.coeff_value  <= '0;
    in_typed           <= 1'b0;
    in_exp_l           <= '0;
    in_exp_r           <= '0;
    sender_calm = 1'b0;
    items_in = 0;
    coef_writes = 0;
    pairs_checked = 0;
    mismatches = 0;
    idle_cycles = 0;
    for (i = 0; i < NCOEF; i++) begin
      coef_tab[i] = '0;
    end
    for (i = 0; i < 2 * BANDS; i++) begin
      delay_line[0][i] = '0;
      delay_line[1][i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clear the table so no unwritten coefficient is ever read
    for (i = 0; i < NCOEF; i++) begin
      send(coef_row(i, 16'sh0));
    end
    foreach (DIR_ROWS[i]) begin
      send(DIR_ROWS[i]);
    end

    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      mode = coef_mode_e'(blk % 3);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < NCOEF; i++) begin
        send(coef_row(i, rand_coef(mode, i % NTAPS)));
      end
      for (i = 0; i < BLOCK_MIXED; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          r = coef_row($urandom_range(0, 63), rand_coef(mode, $urandom_range(0, 4)));
        end else begin
          r = '0;
          r.action = ACT_FILTER;
          r.left   = rand_sample();
          r.right  = rand_sample();
          r.idx    = CIDX_W'($urandom);
          r.value  = smp_t'($urandom);
        end
        send(r);
      end
    end
    in_if.valid <= 1'b0;

    while (eq_pending.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transfers in: %0d coefficient writes, %0d sample pairs; %0d results checked",
             items_in, coef_writes, items_in - coef_writes, pairs_checked);
    $display("gentle, full-range and extreme coefficient sets, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && eq_pending.size() == 0) begin
      $display("stereo_biquad_cascade_equalizer verification clean");
    end else begin
      $display("stereo_biquad_cascade_equalizer verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sbqeq_pkg.sv
rtl/sbqeq_if.sv
rtl/sbqeq_coef_ram.sv
rtl/sbqeq_dly_ram.sv
rtl/sbqeq_dpath.sv
rtl/stereo_biquad_cascade_equalizer.sv
tb/stereo_biquad_cascade_equalizer_test.sv
